### hw/rtl/matrix_multiply_engine_defines.svh
// ----------------------------------------------------------------------------
// Matrix multiply engine assertion macros
// Shorthand for clocked concurrent assertions that are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MME_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Shared widths, register index codes and the MAC control bundle.
// ----------------------------------------------------------------------------
package mme_pkg;

   localparam int DATA_W          = 32;  // element and product width
   localparam int CFG_W           = 4;   // size register width
   localparam int CSR_IDX_W       = 2;   // register index width
   localparam int OUT_IDX_W       = 3;   // row / column tag width
   localparam int DEFAULT_MAX_DIM = 8;

   // register index codes
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B    = 2'd2;

   // control travelling alongside operands into the MAC unit
   typedef struct packed {
      logic vld;
      logic first;  // first term of a dot product: restart the sum
      logic last;   // final term: sum complete after this one
   } mac_ctrl_type;

endpackage

### hw/rtl/mme_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply engine channels
// Valid/ready channels for input elements and product elements.
// ----------------------------------------------------------------------------
interface mme_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [mme_pkg::DATA_W-1:0]   element;

   modport source (output valid, output element, input ready);
   modport sink   (input valid, input element, output ready);
endinterface

interface mme_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [mme_pkg::DATA_W-1:0]      product;
   logic        [mme_pkg::OUT_IDX_W-1:0]   out_row;
   logic        [mme_pkg::OUT_IDX_W-1:0]   out_col;
   logic                                   last;

   modport source (output valid, output product, output out_row, output out_col,
                   output last, input ready);
   modport sink   (input valid, input product, input out_row, input out_col,
                   input last, output ready);
endinterface

### hw/rtl/mme_mac_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply engine MAC unit
// Shared multiply then accumulate, one term per cycle, wrapping at 32 bits.
// ----------------------------------------------------------------------------
module mme_mac_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  mme_pkg::mac_ctrl_type         ctrl,
   input  logic [mme_pkg::DATA_W-1:0]    a_data,
   input  logic [mme_pkg::DATA_W-1:0]    b_data,
   output logic [mme_pkg::DATA_W-1:0]    acc,
   output logic                          done
);

   mme_pkg::mac_ctrl_type          mul_ctrl_ff;
   logic [mme_pkg::DATA_W-1:0]     mul_ff;
   logic [mme_pkg::DATA_W-1:0]     mul_in;
   logic [mme_pkg::DATA_W-1:0]     acc_ff;
   logic [mme_pkg::DATA_W-1:0]     acc_in;
   logic                           done_ff;

   // low word of the product is the same for signed and unsigned operands
   assign mul_in = a_data * b_data;
   assign acc_in = (mul_ctrl_ff.first ? '0 : acc_ff) + mul_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctrl_ff <= '0;
         done_ff     <= 1'b0;
      end else begin
         mul_ctrl_ff <= ctrl;
         done_ff     <= mul_ctrl_ff.vld & mul_ctrl_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.vld) begin
         mul_ff <= mul_in;
      end
      if (mul_ctrl_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

### hw/rtl/matrix_multiply_engine.sv
`timescale 1ns / 1ps
// While loading, an A/B element is taken whenever valid is high; ready marks the load state.
// After the last B element the product is emitted: each element's inner_dim terms are
// read from the stores, multiplied and summed in the shared MAC pipeline, then offered
// on the product channel; the next element starts only once that one is accepted.
// No element is accepted while the product is being computed or emitted.
// Reset (sync, active high): sizes return to 1, loading restarts at A[0][0]; stores keep data.
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Loads A then B into local stores and forms C = A x B on one shared MAC.
// ----------------------------------------------------------------------------
`include "matrix_multiply_engine_defines.svh"

module matrix_multiply_engine #(
   parameter int MAX_DIM = mme_pkg::DEFAULT_MAX_DIM
) (
   input  logic                             clock,
   input  logic                             reset,
   mme_req_if.sink                          req_chan,
   mme_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [mme_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mme_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W  = $clog2(MAX_DIM + 1);

   // sequencer codes
   localparam logic [1:0] S_LOAD = 2'd0;  // taking elements
   localparam logic [1:0] S_MAC  = 2'd1;  // issuing terms of one dot product
   localparam logic [1:0] S_WAIT = 2'd2;  // draining the MAC pipeline
   localparam logic [1:0] S_OUT  = 2'd3;  // product element on offer

   // Size register as used: zero reads as 1, anything above MAX_DIM as MAX_DIM.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [mme_pkg::CFG_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         return DIM_W'(MAX_DIM);
      end else begin
         return DIM_W'(v);
      end
   endfunction

   logic [1:0]                   state_ff, state_in;
   logic [DIM_W-1:0]             dim_r_ff, dim_r_in;
   logic [DIM_W-1:0]             dim_n_ff, dim_n_in;
   logic [DIM_W-1:0]             dim_c_ff, dim_c_in;

   // load position: row/col within A (phase low) or B (phase high)
   logic                         ld_b_ff, ld_b_in;
   logic [IDX_W-1:0]             ld_row_ff, ld_row_in;
   logic [IDX_W-1:0]             ld_col_ff, ld_col_in;

   // compute position
   logic [IDX_W-1:0]             i_ff, i_in;
   logic [IDX_W-1:0]             j_ff, j_in;
   logic [IDX_W-1:0]             k_ff, k_in;

   mme_pkg::mac_ctrl_type        rd_ctrl_ff, rd_ctrl_in;

   logic [mme_pkg::DATA_W-1:0]   a_mem [DEPTH];
   logic [mme_pkg::DATA_W-1:0]   b_mem [DEPTH];
   logic [mme_pkg::DATA_W-1:0]   a_rd_ff;
   logic [mme_pkg::DATA_W-1:0]   b_rd_ff;

   logic                         req_acc;
   logic                         rsp_acc;
   logic                         cfg_hit;
   logic                         ld_col_end;
   logic                         ld_row_end;
   logic                         i_end, j_end, k_end;
   logic [ADDR_W-1:0]            wr_addr;
   logic [ADDR_W-1:0]            a_rd_addr;
   logic [ADDR_W-1:0]            b_rd_addr;
   logic                         a_we, b_we;
   logic [mme_pkg::DATA_W-1:0]   mac_acc;
   logic                         mac_done;

   assign req_acc = req_chan.valid & req_chan.ready;
   assign rsp_acc = rsp_chan.valid & rsp_chan.ready;

   assign cfg_hit = csr_we & ((csr_index == mme_pkg::REG_ROWS_A) ||
                              (csr_index == mme_pkg::REG_INNER_DIM) ||
                              (csr_index == mme_pkg::REG_COLS_B));

   // A is rows_a x inner_dim, B is inner_dim x cols_b
   assign ld_col_end = (DIM_W'(ld_col_ff) + DIM_W'(1)) == (ld_b_ff ? dim_c_ff : dim_n_ff);
   assign ld_row_end = (DIM_W'(ld_row_ff) + DIM_W'(1)) == (ld_b_ff ? dim_n_ff : dim_r_ff);
   assign i_end      = (DIM_W'(i_ff) + DIM_W'(1)) == dim_r_ff;
   assign j_end      = (DIM_W'(j_ff) + DIM_W'(1)) == dim_c_ff;
   assign k_end      = (DIM_W'(k_ff) + DIM_W'(1)) == dim_n_ff;

   // element [r][c] lives at r*MAX_DIM + c in either store
   assign wr_addr   = ADDR_W'(ld_row_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(ld_col_ff);
   assign a_rd_addr = ADDR_W'(i_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(k_ff);
   assign b_rd_addr = ADDR_W'(k_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(j_ff);
   assign a_we      = req_acc & ~ld_b_ff;
   assign b_we      = req_acc & ld_b_ff;

   // Sequencer and size registers
   always_comb begin
      state_in   = state_ff;
      dim_r_in   = dim_r_ff;
      dim_n_in   = dim_n_ff;
      dim_c_in   = dim_c_ff;
      ld_b_in    = ld_b_ff;
      ld_row_in  = ld_row_ff;
      ld_col_in  = ld_col_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      rd_ctrl_in = '0;

      unique case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (ld_col_end) begin
                  ld_col_in = '0;
                  if (ld_row_end) begin
                     ld_row_in = '0;
                     ld_b_in   = ~ld_b_ff;
                     if (ld_b_ff) begin
                        // last B element: start the product
                        state_in = S_MAC;
                        i_in     = '0;
                        j_in     = '0;
                        k_in     = '0;
                     end
                  end else begin
                     ld_row_in = ld_row_ff + IDX_W'(1);
                  end
               end else begin
                  ld_col_in = ld_col_ff + IDX_W'(1);
               end
            end
         end
         S_MAC: begin
            rd_ctrl_in.vld   = 1'b1;
            rd_ctrl_in.first = (k_ff == '0);
            rd_ctrl_in.last  = k_end;
            if (k_end) begin
               k_in     = '0;
               state_in = S_WAIT;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         S_WAIT: begin
            if (mac_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_acc) begin
               if (i_end && j_end) begin
                  state_in = S_LOAD;
               end else begin
                  state_in = S_MAC;
                  if (j_end) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // size write restarts load at A[0][0]; only arrives while idle if the user ensures it
      if (cfg_hit) begin
         ld_b_in   = 1'b0;
         ld_row_in = '0;
         ld_col_in = '0;
         unique case (csr_index)
            mme_pkg::REG_ROWS_A:    dim_r_in = eff_dim(csr_wdata);
            mme_pkg::REG_INNER_DIM: dim_n_in = eff_dim(csr_wdata);
            default:                dim_c_in = eff_dim(csr_wdata);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         dim_r_ff   <= DIM_W'(1);
         dim_n_ff   <= DIM_W'(1);
         dim_c_ff   <= DIM_W'(1);
         ld_b_ff    <= 1'b0;
         ld_row_ff  <= '0;
         ld_col_ff  <= '0;
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
         rd_ctrl_ff <= '0;
      end else begin
         state_ff   <= state_in;
         dim_r_ff   <= dim_r_in;
         dim_n_ff   <= dim_n_in;
         dim_c_ff   <= dim_c_in;
         ld_b_ff    <= ld_b_in;
         ld_row_ff  <= ld_row_in;
         ld_col_ff  <= ld_col_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         k_ff       <= k_in;
         rd_ctrl_ff <= rd_ctrl_in;
      end
   end

   // Element stores: one write and one registered read each
   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[wr_addr] <= req_chan.element;
      end
      a_rd_ff <= a_mem[a_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[wr_addr] <= req_chan.element;
      end
      b_rd_ff <= b_mem[b_rd_addr];
   end

   mme_mac_unit u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (rd_ctrl_ff),
      .a_data (a_rd_ff),
      .b_data (b_rd_ff),
      .acc    (mac_acc),
      .done   (mac_done)
   );

   // Channel outputs
   assign req_chan.ready   = (state_ff == S_LOAD);
   assign rsp_chan.valid   = (state_ff == S_OUT);
   assign rsp_chan.product = mac_acc;
   assign rsp_chan.out_row = mme_pkg::OUT_IDX_W'(i_ff);
   assign rsp_chan.out_col = mme_pkg::OUT_IDX_W'(j_ff);
   assign rsp_chan.last    = i_end & j_end;

   // Assertions
   `MME_ASSERT_SAME(a_done_in_wait, clock, reset,
                    mac_done, state_ff == S_WAIT,
                    "MAC sum completed outside the drain state")
   `MME_ASSERT_SAME(a_issue_from_mac, clock, reset,
                    rd_ctrl_ff.vld, $past(state_ff) == S_MAC,
                    "operand read without an issue cycle")
   `MME_ASSERT_NEXT(a_last_back_to_load, clock, reset,
                    rsp_acc && rsp_chan.last, req_chan.ready,
                    "not back to loading after the final transaction")
   `MME_ASSERT_SAME(a_row_in_range, clock, reset,
                    rsp_chan.valid,
                    (DIM_W'(i_ff) < dim_r_ff) && (DIM_W'(j_ff) < dim_c_ff),
                    "product position outside the matrix")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply engine testbench
// Loads A and B through the element channel, predicts every product element
// on acceptance and checks each product transaction against the oldest one
// predicted. Sizes are changed between runs, and loading is broken off now
// and then by a register write.
// ----------------------------------------------------------------------------
module tb;

   import mme_pkg::*;

   localparam int DIM          = DEFAULT_MAX_DIM;
   localparam int DRAIN_CYCLES = 16;       // settle time once the last product is out
   localparam int RUN_LIMIT_NS = 2000000;  // generous cap on the whole run

   // index with no register behind it: the block must ignore the write
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0]    product;
      logic [OUT_IDX_W-1:0] row;
      logic [OUT_IDX_W-1:0] col;
      logic                 last;
   } product_t;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   mme_req_if req_if ();
   mme_rsp_if rsp_if ();

   matrix_multiply_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predicted block state: sizes as written, stores and load position
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0]  rows_reg;
   logic [CFG_W-1:0]  inner_reg;
   logic [CFG_W-1:0]  cols_reg;
   logic [DATA_W-1:0] a_mem [DIM*DIM];
   logic [DATA_W-1:0] b_mem [DIM*DIM];
   int unsigned       load_cnt;

   product_t product_q [$];   // product elements still owed by the block
   int       error_count = 0;
   bit       idle_enable = 1'b0;
   int       stall_left  = 0;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // size registers: zero acts as one, anything past the array acts as full size
   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
      if (v == '0)
         return 1;
      if (int'(v) > DIM)
         return DIM;
      return int'(v);
   endfunction

   function automatic int unsigned load_total();
      int unsigned n;
      n = clamp_dim(inner_reg);
      return clamp_dim(rows_reg) * n + n * clamp_dim(cols_reg);
   endfunction

   // elements still needed before the block computes
   function automatic int unsigned items_to_finish();
      int unsigned total;
      total = load_total();
      if (load_cnt >= total)
         return total;
      return total - load_cnt;
   endfunction

   // Store one accepted element; on the final B element queue the whole
   // product in row-major order, sums wrapping at 32 bits.
   function automatic void load_element(input logic [DATA_W-1:0] value);
      int unsigned r;
      int unsigned n;
      int unsigned c;
      int unsigned size_a;
      int unsigned total;
      int unsigned idx;
      int unsigned off;
      logic [DATA_W-1:0] acc;
      product_t entry;
      r      = clamp_dim(rows_reg);
      n      = clamp_dim(inner_reg);
      c      = clamp_dim(cols_reg);
      size_a = r * n;
      total  = size_a + n * c;
      idx    = load_cnt;
      if (idx >= total)
         idx = 0;
      if (idx < size_a) begin
         a_mem[(idx / n) * DIM + idx % n] = value;
      end else begin
         off = idx - size_a;
         b_mem[(off / c) * DIM + off % c] = value;
      end
      idx++;
      if (idx < total) begin
         load_cnt = idx;
         return;
      end
      load_cnt = 0;
      for (int unsigned i = 0; i < r; i++) begin
         for (int unsigned j = 0; j < c; j++) begin
            acc = '0;
            for (int unsigned k = 0; k < n; k++)
               acc += a_mem[i * DIM + k] * b_mem[k * DIM + j];
            entry.product = acc;
            entry.row     = OUT_IDX_W'(i);
            entry.col     = OUT_IDX_W'(j);
            entry.last    = (i == r - 1) && (j == c - 1);
            product_q.push_back(entry);
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: one process checks products, applies register writes and
   // predicts on element acceptance, so the order within an edge is fixed
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      product_t want;
      if (reset) begin
         rows_reg  = 4'd1;
         inner_reg = 4'd1;
         cols_reg  = 4'd1;
         load_cnt  = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (product_q.size() == 0) begin
               $error("product transaction with none expected: product %0d row %0d col %0d",
                      $signed(rsp_if.product), rsp_if.out_row, rsp_if.out_col);
               error_count++;
            end else begin
               want = product_q.pop_front();
               if (rsp_if.product !== want.product) begin
                  $error("product: expected %0d, got %0d",
                         $signed(want.product), $signed(rsp_if.product));
                  error_count++;
               end
               if (rsp_if.out_row !== want.row) begin
                  $error("out_row: expected %0d, got %0d", want.row, rsp_if.out_row);
                  error_count++;
               end
               if (rsp_if.out_col !== want.col) begin
                  $error("out_col: expected %0d, got %0d", want.col, rsp_if.out_col);
                  error_count++;
               end
               if (rsp_if.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_if.last);
                  error_count++;
               end
            end
         end
         // any size write restarts loading at A[0][0]
         if (csr_we) begin
            case (csr_index)
               REG_ROWS_A: begin
                  rows_reg = csr_wdata;
                  load_cnt = 0;
               end
               REG_INNER_DIM: begin
                  inner_reg = csr_wdata;
                  load_cnt  = 0;
               end
               REG_COLS_B: begin
                  cols_reg = csr_wdata;
                  load_cnt = 0;
               end
               default: begin
               end
            endcase
         end
         if (req_if.valid && req_if.ready)
            load_element(req_if.element);
      end
   end

   // product sink back-pressure: random stall bursts while idling is enabled
   always @(negedge clock) begin
      if (stall_left != 0)
         stall_left--;
      else if (idle_enable && $urandom_range(0, 4) == 0)
         stall_left = $urandom_range(1, 7);
      rsp_if.ready = (stall_left == 0);
   end

   // ---------------------------------------------------------------------
   // Drivers (called at a falling edge, return at a falling edge)
   // ---------------------------------------------------------------------
   task automatic send_element(input logic [DATA_W-1:0] value);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.element = value;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // drop valid, let every owed product out, then let the engine settle
   task automatic wait_idle();
      req_if.valid = 1'b0;
      while (product_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // extremes, small signed values and full-range noise
   function automatic logic [DATA_W-1:0] pick_element();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return '0;
         4, 5, 6: return $urandom_range(0, 31) - 16;
         default: return $urandom;
      endcase
   endfunction

   // mostly small sizes so runs stay short; now and then out-of-range values
   function automatic logic [CFG_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return CFG_W'($urandom_range(0, 15));
         1:       return CFG_W'($urandom_range(5, 8));
         default: return CFG_W'($urandom_range(1, 4));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // sizes straight out of reset are 1x1x1: scalar products at the extremes
   task automatic test_reset_sizes();
      send_element(32'h7fff_ffff);
      send_element(32'h7fff_ffff);
      send_element(32'h8000_0000);
      send_element(32'h8000_0000);
      send_element(32'h8000_0000);
      send_element(32'hffff_ffff);
      send_element(32'h0000_0000);
      send_element(32'h5a5a_a5a5);
   endtask

   // zero sizes act as one, oversize columns act as full width
   task automatic test_size_clamp();
      wait_idle();
      write_reg(REG_ROWS_A, 4'd0);
      write_reg(REG_INNER_DIM, 4'd0);
      write_reg(REG_COLS_B, 4'd9);
      repeat (items_to_finish()) send_element(pick_element());
   endtask

   // a size write mid-load restarts at A[0][0]; a write to the spare index does not
   task automatic test_reload_restart();
      wait_idle();
      write_reg(REG_ROWS_A, 4'd2);
      write_reg(REG_INNER_DIM, 4'd1);
      write_reg(REG_COLS_B, 4'd1);
      send_element(32'h1234_5678);
      wait_idle();
      write_reg(REG_INNER_DIM, 4'd1);
      send_element(32'hffff_fffd);
      wait_idle();
      write_reg(REG_UNUSED, 4'hf);
      repeat (items_to_finish()) send_element(pick_element());
   endtask

   // full-size product, then the widest output (64 elements from inner of one)
   task automatic test_max_size();
      idle_enable = 1'b1;
      wait_idle();
      write_reg(REG_ROWS_A, 4'd8);
      write_reg(REG_INNER_DIM, 4'd8);
      write_reg(REG_COLS_B, 4'd8);
      repeat (items_to_finish()) send_element(pick_element());
      wait_idle();
      write_reg(REG_ROWS_A, 4'd15);
      write_reg(REG_INNER_DIM, 4'd1);
      write_reg(REG_COLS_B, 4'd15);
      repeat (items_to_finish()) send_element(pick_element());
   endtask

   // Random runs: fresh sizes, random content; now and then loading is cut
   // short and the next run starts with whatever writes it draws.
   task automatic run_random(input int budget, input bit allow_idle);
      int          sent;
      int unsigned count;
      sent = 0;
      while (sent < budget) begin
         idle_enable = allow_idle && ($urandom_range(0, 3) != 0);
         wait_idle();
         if ($urandom_range(0, 1))
            write_reg(REG_ROWS_A, pick_size());
         if ($urandom_range(0, 1))
            write_reg(REG_INNER_DIM, pick_size());
         if ($urandom_range(0, 1))
            write_reg(REG_COLS_B, pick_size());
         if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 15)));
         count = items_to_finish();
         if (count > 1 && $urandom_range(0, 5) == 0)
            count = $urandom_range(1, count - 1);
         repeat (count) send_element(pick_element());
         sent += count;
      end
   endtask

   task automatic test_random_runs();
      run_random(24, 1'b1);
   endtask

   // closing stretch with no idling on either side
   task automatic test_back_to_back();
      run_random(12, 1'b0);
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = REG_ROWS_A;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.element = '0;
      rsp_if.ready   = 1'b1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_reset_sizes();
      test_size_clamp();
      test_reload_restart();
      test_max_size();
      test_random_runs();
      test_back_to_back();

      wait_idle();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // hang guard
   initial begin
      #(RUN_LIMIT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
